// ===== hw/rtl/laserdisc_vbi_frame_decoder_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; included by lvbi_checker.sv.
`ifndef LASERDISC_VBI_FRAME_DECODER_MACROS_SVH
`define LASERDISC_VBI_FRAME_DECODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LVBI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lvbi assertion failed");

// next-cycle implication, disabled while in reset
`define LVBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lvbi assertion failed");

`endif

// ===== hw/rtl/lvbi_pkg.sv =====
// Types, code constants and small lookup/BCD functions for the VBI frame decoder.
// No dependencies; used by every module of the block.
package lvbi_pkg;

    localparam int LINE_W    = 25;
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 96;

    localparam logic [LINE_W-1:0] LINE_ABSENT = 25'h1FFFFFF;
    localparam logic [LINE_W-1:0] CODE_LEADIN = 25'h088FFFF;
    localparam logic [LINE_W-1:0] CODE_LEADOUT = 25'h080EEEE;
    localparam logic [LINE_W-1:0] CODE_STOP   = 25'h082CFFF;
    localparam logic [LINE_W-1:0] CODE_CLV    = 25'h087FFFF;
    localparam logic [23:0] MASK_CHAP  = 24'hF00FFF;
    localparam logic [23:0] CODE_CHAP  = 24'h800DDD;
    localparam logic [23:0] MASK_TIME  = 24'hF0FF00;
    localparam logic [23:0] CODE_TIME  = 24'hF0DD00;
    localparam logic [11:0] CODE_STAT_CX = 12'h8DC;
    localparam logic [11:0] CODE_STAT    = 12'h8BA;
    localparam logic [3:0]  NIB_PIC   = 4'hF;
    localparam logic [3:0]  NIB_EIGHT = 4'h8;
    localparam logic [3:0]  NIB_USER  = 4'hD;
    localparam logic [3:0]  NIB_CPIC  = 4'hE;
    localparam logic [3:0]  NIB_SEC_BASE = 4'hA;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CAV  = 2'd1;
    localparam logic [1:0] KIND_CLV  = 2'd2;

    localparam logic [3:0] SND_FUTURE = 4'd2;

    localparam int FLG_LEADIN   = 0;
    localparam int FLG_LEADOUT  = 1;
    localparam int FLG_STOP     = 2;
    localparam int FLG_CX       = 3;
    localparam int FLG_SIZE12   = 4;
    localparam int FLG_SIDE1    = 5;
    localparam int FLG_TELETEXT = 6;
    localparam int FLG_DUMP     = 7;
    localparam int FLG_FM       = 8;
    localparam int FLG_DIGITAL  = 9;
    localparam int FLG_PARITY   = 10;
    localparam int FLG_COPY     = 11;
    localparam int FLG_STD      = 12;
    localparam int FLG_W        = 13;

    // decoded frame or field record; picture, chapter, time and CLV picture numbers use all ones for "none"
    typedef struct packed {
        logic [1:0]       kind;
        logic [17:0]      pic;
        logic [7:0]       chap;
        logic [4:0]       hr;
        logic [7:0]       mn;
        logic [6:0]       sec;
        logic [7:0]       cpic;
        logic [15:0]      user;
        logic             user_ok;
        logic [3:0]       snd;
        logic [3:0]       snd2;
        logic [FLG_W-1:0] flags;
    } rec_t;

    function automatic logic nib_ok(input logic [3:0] n);
        return n <= 4'd9;
    endfunction

    function automatic logic [6:0] bcd2(input logic [7:0] v);
        return 7'(v[7:4]) * 7'd10 + 7'(v[3:0]);
    endfunction

    function automatic logic [16:0] bcd5(input logic [18:0] v);
        return 17'(v[18:16]) * 17'd10000 + 17'(v[15:12]) * 17'd1000
             + 17'(v[11:8]) * 17'd100 + 17'(v[7:4]) * 17'd10 + 17'(v[3:0]);
    endfunction

    function automatic logic [3:0] audio_mode(input logic [3:0] a);
        logic [3:0] r;
        unique case (a)
            4'd0:  r = 4'd0;
            4'd1:  r = 4'd1;
            4'd2:  r = 4'd2;
            4'd3:  r = 4'd3;
            4'd4:  r = 4'd4;
            4'd5:  r = 4'd5;
            4'd6:  r = 4'd6;
            4'd7:  r = 4'd7;
            4'd8:  r = 4'd8;
            4'd9:  r = 4'd8;
            4'd10: r = 4'd2;
            4'd11: r = 4'd8;
            4'd12: r = 4'd9;
            4'd13: r = 4'd9;
            4'd14: r = 4'd10;
            default: r = 4'd10;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] audio_mode_am2(input logic [3:0] a);
        logic [3:0] r;
        unique case (a)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd1;
            4'd3:    r = 4'd3;
            4'd8:    r = 4'd8;
            default: r = SND_FUTURE;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/lvbi_field_dec.sv =====
// Decodes the line 16/17/18 VBI codes of one field into a record.
// Depends on lvbi_pkg.
module lvbi_field_dec (
    input  logic [lvbi_pkg::LINE_W-1:0] l16,
    input  logic [lvbi_pkg::LINE_W-1:0] l17,
    input  logic [lvbi_pkg::LINE_W-1:0] l18,
    output lvbi_pkg::rec_t              rec
);

    logic             absent;
    logic             pic17, pic18, chap17, chap18, time17, time18;
    logic             stop, clv_code, status, user_hit, cpic_hit;
    logic [3:0]       x1, x3, x4, x5, aud;
    logic             a41, a42, a43, a44, par;
    logic [lvbi_pkg::FLG_W-1:0] flags;
    lvbi_pkg::rec_t   r;

    assign absent = (l16 == lvbi_pkg::LINE_ABSENT) && (l17 == lvbi_pkg::LINE_ABSENT)
                 && (l18 == lvbi_pkg::LINE_ABSENT);

    assign pic17 = (l17[23:20] == lvbi_pkg::NIB_PIC) && lvbi_pkg::nib_ok(l17[15:12])
                && lvbi_pkg::nib_ok(l17[11:8]) && lvbi_pkg::nib_ok(l17[7:4])
                && lvbi_pkg::nib_ok(l17[3:0]);
    assign pic18 = (l18[23:20] == lvbi_pkg::NIB_PIC) && lvbi_pkg::nib_ok(l18[15:12])
                && lvbi_pkg::nib_ok(l18[11:8]) && lvbi_pkg::nib_ok(l18[7:4])
                && lvbi_pkg::nib_ok(l18[3:0]);

    assign chap17 = ((l17[23:0] & lvbi_pkg::MASK_CHAP) == lvbi_pkg::CODE_CHAP)
                 && lvbi_pkg::nib_ok(l17[15:12]);
    assign chap18 = ((l18[23:0] & lvbi_pkg::MASK_CHAP) == lvbi_pkg::CODE_CHAP)
                 && lvbi_pkg::nib_ok(l18[15:12]);

    assign time17 = ((l17[23:0] & lvbi_pkg::MASK_TIME) == lvbi_pkg::CODE_TIME)
                 && lvbi_pkg::nib_ok(l17[19:16]) && lvbi_pkg::nib_ok(l17[7:4])
                 && lvbi_pkg::nib_ok(l17[3:0]);
    assign time18 = ((l18[23:0] & lvbi_pkg::MASK_TIME) == lvbi_pkg::CODE_TIME)
                 && lvbi_pkg::nib_ok(l18[19:16]) && lvbi_pkg::nib_ok(l18[7:4])
                 && lvbi_pkg::nib_ok(l18[3:0]);

    assign stop     = (l16 == lvbi_pkg::CODE_STOP) || (l17 == lvbi_pkg::CODE_STOP);
    assign clv_code = (l17 == lvbi_pkg::CODE_CLV);
    assign status   = (l16[23:12] == lvbi_pkg::CODE_STAT_CX)
                   || (l16[23:12] == lvbi_pkg::CODE_STAT);

    assign x1 = l16[19:16];
    assign x3 = l16[11:8];
    assign x4 = l16[7:4];
    assign x5 = l16[3:0];

    assign user_hit = (l16[23:20] == lvbi_pkg::NIB_EIGHT) && (l16[15:12] == lvbi_pkg::NIB_USER);
    assign cpic_hit = (l16[23:20] == lvbi_pkg::NIB_EIGHT) && (l16[15:12] == lvbi_pkg::NIB_CPIC)
                   && (x1 >= lvbi_pkg::NIB_SEC_BASE) && lvbi_pkg::nib_ok(x3)
                   && lvbi_pkg::nib_ok(x4) && lvbi_pkg::nib_ok(x5);

    assign a41 = x4[3];
    assign a42 = x4[2];
    assign a43 = x4[1];
    assign a44 = x4[0];
    assign aud = {a41, x3[0], a43, a44};
    assign par = ((a41 ^ a42 ^ a44) == x5[3]) && ((a41 ^ a43 ^ a44) == x5[2])
              && ((a42 ^ a43 ^ a44) == x5[1]);

    always_comb
    begin
        flags = '0;
        flags[lvbi_pkg::FLG_LEADIN]  = (l17 == lvbi_pkg::CODE_LEADIN)
                                    || (l18 == lvbi_pkg::CODE_LEADIN);
        flags[lvbi_pkg::FLG_LEADOUT] = (l17 == lvbi_pkg::CODE_LEADOUT)
                                    || (l18 == lvbi_pkg::CODE_LEADOUT);
        flags[lvbi_pkg::FLG_STOP]    = stop;
        if (status)
        begin
            flags[lvbi_pkg::FLG_CX]       = (l16[23:12] == lvbi_pkg::CODE_STAT_CX);
            flags[lvbi_pkg::FLG_SIZE12]   = !x3[3];
            flags[lvbi_pkg::FLG_SIDE1]    = !x3[2];
            flags[lvbi_pkg::FLG_TELETEXT] = x3[1];
            flags[lvbi_pkg::FLG_DUMP]     = aud[3];
            flags[lvbi_pkg::FLG_FM]       = aud[2];
            flags[lvbi_pkg::FLG_DIGITAL]  = a42;
            flags[lvbi_pkg::FLG_PARITY]   = par;
            flags[lvbi_pkg::FLG_COPY]     = x3[0];
            flags[lvbi_pkg::FLG_STD]      = (x4 == 4'd0) || (x4 == 4'd1) || (x4 == 4'd3)
                                         || (x4 == 4'd8);
        end
    end

    always_comb
    begin
        r = '1;
        r.flags = flags;

        if (cpic_hit || time17 || time18 || clv_code)
            r.kind = lvbi_pkg::KIND_CLV;
        else if (pic17 || pic18 || stop)
            r.kind = lvbi_pkg::KIND_CAV;
        else
            r.kind = lvbi_pkg::KIND_NONE;

        if (cpic_hit)
            r.pic = '1;
        else if (pic18)
            r.pic = {1'b0, lvbi_pkg::bcd5(l18[18:0])};
        else if (pic17)
            r.pic = {1'b0, lvbi_pkg::bcd5(l17[18:0])};

        if (chap18)
            r.chap = {1'b0, lvbi_pkg::bcd2({1'b0, l18[18:12]})};
        else if (chap17)
            r.chap = {1'b0, lvbi_pkg::bcd2({1'b0, l17[18:12]})};

        if (time18)
        begin
            r.hr = {1'b0, l18[19:16]};
            r.mn = {1'b0, lvbi_pkg::bcd2(l18[7:0])};
        end
        else if (time17)
        begin
            r.hr = {1'b0, l17[19:16]};
            r.mn = {1'b0, lvbi_pkg::bcd2(l17[7:0])};
        end

        if (cpic_hit)
        begin
            r.cpic = {1'b0, lvbi_pkg::bcd2(l16[7:0])};
            r.sec  = 7'(3'(x1 - lvbi_pkg::NIB_SEC_BASE)) * 7'd10 + 7'(x3);
        end

        r.user_ok = user_hit;
        r.user    = user_hit ? {x1, l16[11:0]} : 16'd0;

        r.snd  = status ? lvbi_pkg::audio_mode(aud)    : lvbi_pkg::SND_FUTURE;
        r.snd2 = status ? lvbi_pkg::audio_mode_am2(x4) : lvbi_pkg::SND_FUTURE;

        if (absent)
        begin
            r         = '1;
            r.kind    = lvbi_pkg::KIND_NONE;
            r.user    = '0;
            r.user_ok = 1'b0;
            r.snd     = lvbi_pkg::SND_FUTURE;
            r.snd2    = lvbi_pkg::SND_FUTURE;
            r.flags   = '0;
        end
    end

    assign rec = r;

endmodule

// ===== hw/rtl/laserdisc_vbi_frame_decoder.sv =====
// Top level of the laserdisc VBI frame decoder: input register, two field
// decoders, merge and result register. Depends on lvbi_pkg and lvbi_field_dec.
//
//  channel  dir  beat contents
//  s_*      in   six 25-bit line codes (field 1 lines 16..18, field 2 lines 16..18)
//  m_*      out  merged frame record (kind, numbers, user code, sound modes, flags)
//
// One beat per cycle while s_tready is high.
// The decode sits between the input register and the result register.
// rst_n clears only the valid bits; payload registers are not reset.
// A stalled result holds in the result register while the input register can
// still take one more beat; s_tready drops only when both are full and m_tready is low.
module laserdisc_vbi_frame_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [24:0] first_line16, [49:25] first_line17, [74:50] first_line18,
    // [99:75] second_line16, [124:100] second_line17, [149:125] second_line18, zero pad
    input  logic [lvbi_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] disc_kind, [19:2] picture_number, [27:20] chapter_number,
    // [32:28] clv_hours, [40:33] clv_minutes, [47:41] clv_seconds,
    // [55:48] clv_picture, [71:56] user_code, [72] user_code_valid,
    // [76:73] sound_mode, [80:77] sound_mode_am2, [93:81] flag_bits, zero pad
    output logic [lvbi_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int LW = lvbi_pkg::LINE_W;

    logic                           in_valid_reg, in_valid_next;
    logic [lvbi_pkg::S_TDATA_W-1:0] in_data_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [lvbi_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                           out_en, in_en;
    lvbi_pkg::rec_t                 rec_a, rec_b, rec_m;

    assign out_en   = !out_valid_reg || m_tready;
    assign in_en    = !in_valid_reg || out_en;
    assign s_tready = in_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    lvbi_field_dec u_dec_a (
        .l16 (in_data_reg[LW-1:0]),
        .l17 (in_data_reg[2*LW-1:LW]),
        .l18 (in_data_reg[3*LW-1:2*LW]),
        .rec (rec_a)
    );

    lvbi_field_dec u_dec_b (
        .l16 (in_data_reg[4*LW-1:3*LW]),
        .l17 (in_data_reg[5*LW-1:4*LW]),
        .l18 (in_data_reg[6*LW-1:5*LW]),
        .rec (rec_b)
    );

    // first field wins unless unset; flags are ORed
    always_comb
    begin
        rec_m.kind  = (rec_a.kind != lvbi_pkg::KIND_NONE) ? rec_a.kind : rec_b.kind;
        rec_m.pic   = (rec_a.pic  != '1) ? rec_a.pic  : rec_b.pic;
        rec_m.chap  = (rec_a.chap != '1) ? rec_a.chap : rec_b.chap;
        rec_m.hr    = (rec_a.hr   != '1) ? rec_a.hr   : rec_b.hr;
        rec_m.mn    = (rec_a.mn   != '1) ? rec_a.mn   : rec_b.mn;
        rec_m.sec   = (rec_a.sec  != '1) ? rec_a.sec  : rec_b.sec;
        rec_m.cpic  = (rec_a.cpic != '1) ? rec_a.cpic : rec_b.cpic;
        rec_m.user_ok = rec_a.user_ok || rec_b.user_ok;
        rec_m.user  = rec_a.user_ok ? rec_a.user : rec_b.user;
        rec_m.snd   = (rec_a.snd  != lvbi_pkg::SND_FUTURE) ? rec_a.snd  : rec_b.snd;
        rec_m.snd2  = (rec_a.snd2 != lvbi_pkg::SND_FUTURE) ? rec_a.snd2 : rec_b.snd2;
        rec_m.flags = rec_a.flags | rec_b.flags;
    end

    always_comb
    begin
        out_data_next = {2'b00, rec_m.flags, rec_m.snd2, rec_m.snd, rec_m.user_ok,
                         rec_m.user, rec_m.cpic, rec_m.sec, rec_m.mn, rec_m.hr,
                         rec_m.chap, rec_m.pic, rec_m.kind};
        in_valid_next  = in_en ? s_tvalid : in_valid_reg;
        out_valid_next = out_en ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_en)
            in_data_reg <= s_tdata;
        if (in_valid_reg && out_en)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== hw/rtl/lvbi_checker.sv =====
// Port-level assertions for the VBI frame decoder, bound to the top level.
// Depends on lvbi_pkg and laserdisc_vbi_frame_decoder_macros.svh.
`include "laserdisc_vbi_frame_decoder_macros.svh"

module lvbi_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lvbi_pkg::M_TDATA_W-1:0] m_tdata
);

    logic in_beat;
    logic hr_none;
    logic mn_none;

    assign in_beat = s_tvalid && s_tready;
    assign hr_none = (m_tdata[32:28] == 5'h1F);
    assign mn_none = (m_tdata[40:33] == 8'hFF);

    // a stalled result beat holds
    `LVBI_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // disc kind never carries the unused code
    `LVBI_ASSERT_NOW(a_kind, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3)

    // hours and minutes come from the same line, so both are set or neither
    `LVBI_ASSERT_NOW(a_time, clk, rst_n, m_tvalid, hr_none == mn_none)

    // no user code means zero digits
    `LVBI_ASSERT_NOW(a_user, clk, rst_n, m_tvalid && !m_tdata[72], m_tdata[71:56] == 16'd0)

    // once a beat is accepted while m_tready is high, m_tvalid is high after it has passed the input register
    `LVBI_ASSERT_NEXT(a_flow, clk, rst_n, in_beat && m_tready, ##1 m_tvalid)

endmodule

bind laserdisc_vbi_frame_decoder lvbi_checker u_lvbi_checker (.*);
